[src/horizontal_three_tap_filter_unit_macros.svh]
// Assertion macros for the horizontal three-tap filter unit.
// Depends on nothing; included by the checker file.
`ifndef HORIZONTAL_THREE_TAP_FILTER_UNIT_MACROS_SVH
`define HORIZONTAL_THREE_TAP_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HTF_ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
    else $error("htf check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define HTF_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
    else $error("htf check failed: next-cycle implication");

`endif

[src/htf_pkg.sv]
// Shared types and constants of the horizontal three-tap filter unit.
// Used by the front, queue, back and top-level modules.
package htf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEFF_W  = 8;
  localparam int ROW_W    = 13;
  localparam int PROD_W   = SAMPLE_W + COEFF_W;
  localparam int KSUM_W   = COEFF_W + 2;
  localparam int NUM_W    = PROD_W + 2;
  // Dividend 2*|num| + |sum| stays below 2^25 for all operands.
  localparam int DVD_W    = 25;
  localparam int DIV_W    = 10;
  localparam int DCNT_W   = 5;

  localparam int Q_DEPTH  = 4;
  localparam int Q_PTR_W  = 2;
  localparam int Q_CNT_W  = 3;

  localparam logic [ROW_W-1:0]          RST_ROW_WIDTH = 13'd4096;
  localparam logic signed [COEFF_W-1:0] RST_COEFF_L   = 8'sd1;
  localparam logic signed [COEFF_W-1:0] RST_COEFF_C   = 8'sd2;
  localparam logic signed [COEFF_W-1:0] RST_COEFF_R   = 8'sd1;

  localparam logic [DVD_W-1:0] SAT_POS_MAG = 25'd32767;
  localparam logic [DVD_W-1:0] SAT_NEG_MAG = 25'd32768;
  localparam logic signed [SAMPLE_W-1:0] SAT_POS = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAT_NEG = 16'sh8000;

  typedef enum logic [1:0] {
    REG_ROW_WIDTH   = 2'd0,
    REG_COEFF_LEFT  = 2'd1,
    REG_COEFF_CENTRE = 2'd2,
    REG_COEFF_RIGHT = 2'd3
  } htf_reg_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_ADD,
    B_DIV,
    B_FIN
  } htf_bstate_t;

  typedef struct packed {
    logic [ROW_W-1:0]          row_width;
    logic signed [COEFF_W-1:0] coeff_left;
    logic signed [COEFF_W-1:0] coeff_centre;
    logic signed [COEFF_W-1:0] coeff_right;
  } htf_cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] centre;
    logic signed [SAMPLE_W-1:0] right;
    logic                       last;
  } htf_job_t;

endpackage

[src/horizontal_three_tap_filter_unit.sv]
// Each result holds the back-end divider through fetch, multiply, add, 25
// divide steps and output, so the back end takes no new job until the last
// result has entered the output register; the front takes a pixel per cycle
// while its 4-entry queue has room and no second row-end result is pending.
// Reset (synchronous, active low) empties the queue and pipeline, clears the row
// position and loads the register defaults; there is no clearing pass.
module horizontal_three_tap_filter_unit #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] filtered
  output logic        out_tlast,
  output logic        out_tuser,  // [0] zero_sum_error
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_wdata
);

  htf_pkg::htf_cfg_t cfg_r, cfg_nxt;
  htf_pkg::htf_job_t push_job;
  htf_pkg::htf_job_t pop_job;
  logic              push_valid;
  logic              push_ready;
  logic              pop_valid;
  logic              pop_ready;
  logic signed [15:0] filtered;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (htf_pkg::htf_reg_t'(cfg_index))
        htf_pkg::REG_ROW_WIDTH:    cfg_nxt.row_width    = cfg_wdata;
        htf_pkg::REG_COEFF_LEFT:   cfg_nxt.coeff_left   = cfg_wdata[7:0];
        htf_pkg::REG_COEFF_CENTRE: cfg_nxt.coeff_centre = cfg_wdata[7:0];
        htf_pkg::REG_COEFF_RIGHT:  cfg_nxt.coeff_right  = cfg_wdata[7:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{row_width:    htf_pkg::RST_ROW_WIDTH,
                 coeff_left:   htf_pkg::RST_COEFF_L,
                 coeff_centre: htf_pkg::RST_COEFF_C,
                 coeff_right:  htf_pkg::RST_COEFF_R};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  htf_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .row_width  (cfg_r.row_width),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .sample     (in_tdata),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready)
  );

  htf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_job    (pop_job),
    .pop_ready  (pop_ready)
  );

  htf_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .pop_valid    (pop_valid),
    .pop_job      (pop_job),
    .pop_ready    (pop_ready),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_filtered (filtered),
    .out_last     (out_tlast),
    .out_err      (out_tuser)
  );

  assign out_tdata = filtered;

endmodule

[src/htf_front.sv]
// Front end: accepts pixels, tracks the row position and turns each pixel
// into zero, one or two filter jobs. Depends on htf_pkg.
module htf_front #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [htf_pkg::ROW_W-1:0]           row_width,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [htf_pkg::SAMPLE_W-1:0] sample,
  output logic                                push_valid,
  output htf_pkg::htf_job_t                   push_job,
  input  logic                                push_ready
);

  localparam int CNT_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int W_W   = $clog2(MAX_WIDTH + 1);

  logic signed [htf_pkg::SAMPLE_W-1:0] left_r, left_nxt;
  logic signed [htf_pkg::SAMPLE_W-1:0] centre_r, centre_nxt;
  logic [CNT_W-1:0]                    cnt_r, cnt_nxt;
  logic                                pend_r, pend_nxt;
  htf_pkg::htf_job_t                   pend_job_r, pend_job_nxt;

  logic [W_W-1:0] w_eff;
  logic           is_one;
  logic           at_end;
  logic           accept;

  // Out-of-range widths clamp to one pixel or to the maximum row.
  always_comb begin
    if (row_width == '0) begin
      w_eff = W_W'(1);
    end else if (32'(row_width) > MAX_WIDTH) begin
      w_eff = W_W'(MAX_WIDTH);
    end else begin
      w_eff = W_W'(row_width);
    end
  end

  assign is_one   = (w_eff == W_W'(1));
  assign at_end   = (W_W'(cnt_r) >= (w_eff - W_W'(1)));
  assign in_ready = !pend_r && push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    left_nxt     = left_r;
    centre_nxt   = centre_r;
    cnt_nxt      = cnt_r;
    pend_nxt     = pend_r;
    pend_job_nxt = pend_job_r;
    push_valid   = 1'b0;
    push_job     = pend_job_r;
    if (pend_r) begin
      // The second result of a row end goes out before the next pixel.
      push_valid = 1'b1;
      if (push_ready) begin
        pend_nxt = 1'b0;
      end
    end else if (accept) begin
      priority if (is_one) begin
        push_valid = 1'b1;
        push_job   = '{left: '0, centre: sample, right: '0, last: 1'b1};
        left_nxt   = '0;
        centre_nxt = '0;
        cnt_nxt    = '0;
      end else if (cnt_r == '0) begin
        left_nxt   = '0;
        centre_nxt = sample;
        cnt_nxt    = CNT_W'(1);
      end else if (at_end) begin
        push_valid   = 1'b1;
        push_job     = '{left: left_r, centre: centre_r, right: sample, last: 1'b0};
        pend_nxt     = 1'b1;
        pend_job_nxt = '{left: centre_r, centre: sample, right: '0, last: 1'b1};
        left_nxt     = '0;
        centre_nxt   = '0;
        cnt_nxt      = '0;
      end else begin
        push_valid = 1'b1;
        push_job   = '{left: left_r, centre: centre_r, right: sample, last: 1'b0};
        left_nxt   = centre_r;
        centre_nxt = sample;
        cnt_nxt    = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      centre_r <= '0;
      cnt_r    <= '0;
      pend_r   <= 1'b0;
    end else begin
      left_r   <= left_nxt;
      centre_r <= centre_nxt;
      cnt_r    <= cnt_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_job_r <= pend_job_nxt;
  end

endmodule

[src/htf_queue.sv]
// Short job queue between the front end and the arithmetic back end.
// Depends on htf_pkg for the job type and depth.
module htf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  htf_pkg::htf_job_t push_job,
  output logic              push_ready,
  output logic              pop_valid,
  output htf_pkg::htf_job_t pop_job,
  input  logic              pop_ready
);

  htf_pkg::htf_job_t               mem_r [htf_pkg::Q_DEPTH];
  logic [htf_pkg::Q_PTR_W-1:0]     wr_r, wr_nxt;
  logic [htf_pkg::Q_PTR_W-1:0]     rd_r, rd_nxt;
  logic [htf_pkg::Q_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = (cnt_r != htf_pkg::Q_CNT_W'(htf_pkg::Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_nxt  = do_push ? wr_r + htf_pkg::Q_PTR_W'(1) : wr_r;
    rd_nxt  = do_pop ? rd_r + htf_pkg::Q_PTR_W'(1) : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + htf_pkg::Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - htf_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_job;
    end
  end

endmodule

[src/htf_back.sv]
// Back end: weighted sum, rounded division by the coefficient sum with a
// bit-serial restoring divider, saturation and the output register.
// Depends on htf_pkg.
module htf_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  htf_pkg::htf_cfg_t                    cfg,
  input  logic                                 pop_valid,
  input  htf_pkg::htf_job_t                    pop_job,
  output logic                                 pop_ready,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [htf_pkg::SAMPLE_W-1:0]  out_filtered,
  output logic                                 out_last,
  output logic                                 out_err
);

  htf_pkg::htf_bstate_t st_r, st_nxt;
  htf_pkg::htf_job_t    job_r, job_nxt;

  logic signed [htf_pkg::PROD_W-1:0]   p0_r, p0_nxt;
  logic signed [htf_pkg::PROD_W-1:0]   p1_r, p1_nxt;
  logic signed [htf_pkg::PROD_W-1:0]   p2_r, p2_nxt;
  logic                                neg_r, neg_nxt;
  logic                                err_r, err_nxt;
  logic [htf_pkg::DVD_W-1:0]           dq_r, dq_nxt;
  logic [htf_pkg::DIV_W-1:0]           rem_r, rem_nxt;
  logic [htf_pkg::DIV_W-1:0]           div_r, div_nxt;
  logic [htf_pkg::DCNT_W-1:0]          dcnt_r, dcnt_nxt;

  logic                                ov_r, ov_nxt;
  logic signed [htf_pkg::SAMPLE_W-1:0] of_r, of_nxt;
  logic                                ol_r, ol_nxt;
  logic                                oe_r, oe_nxt;

  logic signed [htf_pkg::KSUM_W-1:0]   ksum;
  logic [htf_pkg::KSUM_W-1:0]          kabs;
  logic signed [htf_pkg::NUM_W-1:0]    num;
  logic [htf_pkg::NUM_W-1:0]           nabs;
  logic [htf_pkg::DIV_W:0]             trial;
  logic signed [htf_pkg::SAMPLE_W-1:0] qval;
  logic                                out_free;

  assign ksum = htf_pkg::KSUM_W'(cfg.coeff_left) + htf_pkg::KSUM_W'(cfg.coeff_centre)
              + htf_pkg::KSUM_W'(cfg.coeff_right);
  assign kabs = ksum[htf_pkg::KSUM_W-1] ? -ksum : ksum;
  assign num  = htf_pkg::NUM_W'(p0_r) + htf_pkg::NUM_W'(p1_r) + htf_pkg::NUM_W'(p2_r);
  assign nabs = num[htf_pkg::NUM_W-1] ? -num : num;
  assign trial = {rem_r, dq_r[htf_pkg::DVD_W-1]};
  assign out_free = !ov_r || out_ready;

  // Magnitude is the rounded quotient; apply the sign, then saturate.
  always_comb begin
    if (err_r) begin
      qval = '0;
    end else if (!neg_r) begin
      qval = (dq_r > htf_pkg::SAT_POS_MAG) ? htf_pkg::SAT_POS
                                           : dq_r[htf_pkg::SAMPLE_W-1:0];
    end else begin
      qval = (dq_r > htf_pkg::SAT_NEG_MAG) ? htf_pkg::SAT_NEG
                                           : -dq_r[htf_pkg::SAMPLE_W-1:0];
    end
  end

  always_comb begin
    st_nxt    = st_r;
    job_nxt   = job_r;
    p0_nxt    = p0_r;
    p1_nxt    = p1_r;
    p2_nxt    = p2_r;
    neg_nxt   = neg_r;
    err_nxt   = err_r;
    dq_nxt    = dq_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    dcnt_nxt  = dcnt_r;
    ov_nxt    = ov_r && !out_ready;
    of_nxt    = of_r;
    ol_nxt    = ol_r;
    oe_nxt    = oe_r;
    pop_ready = 1'b0;
    unique case (st_r)
      htf_pkg::B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          job_nxt = pop_job;
          st_nxt  = htf_pkg::B_MUL;
        end
      end
      htf_pkg::B_MUL: begin
        p0_nxt = job_r.left * cfg.coeff_left;
        p1_nxt = job_r.centre * cfg.coeff_centre;
        p2_nxt = job_r.right * cfg.coeff_right;
        st_nxt = htf_pkg::B_ADD;
      end
      htf_pkg::B_ADD: begin
        neg_nxt  = num[htf_pkg::NUM_W-1] != ksum[htf_pkg::KSUM_W-1];
        err_nxt  = (ksum == '0);
        dq_nxt   = {nabs[htf_pkg::DVD_W-2:0], 1'b0} + htf_pkg::DVD_W'(kabs);
        div_nxt  = {kabs[htf_pkg::DIV_W-2:0], 1'b0};
        rem_nxt  = '0;
        dcnt_nxt = htf_pkg::DCNT_W'(htf_pkg::DVD_W - 1);
        st_nxt   = (ksum == '0) ? htf_pkg::B_FIN : htf_pkg::B_DIV;
      end
      htf_pkg::B_DIV: begin
        // One quotient bit per cycle; the remainder stays below the divisor.
        if (trial >= {1'b0, div_r}) begin
          rem_nxt = htf_pkg::DIV_W'(trial - {1'b0, div_r});
          dq_nxt  = {dq_r[htf_pkg::DVD_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[htf_pkg::DIV_W-1:0];
          dq_nxt  = {dq_r[htf_pkg::DVD_W-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r - htf_pkg::DCNT_W'(1);
        if (dcnt_r == '0) begin
          st_nxt = htf_pkg::B_FIN;
        end
      end
      htf_pkg::B_FIN: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          of_nxt = qval;
          ol_nxt = job_r.last;
          oe_nxt = err_r;
          st_nxt = htf_pkg::B_IDLE;
        end
      end
      default: begin
        st_nxt = htf_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= htf_pkg::B_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    p0_r   <= p0_nxt;
    p1_r   <= p1_nxt;
    p2_r   <= p2_nxt;
    neg_r  <= neg_nxt;
    err_r  <= err_nxt;
    dq_r   <= dq_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    dcnt_r <= dcnt_nxt;
    of_r   <= of_nxt;
    ol_r   <= ol_nxt;
    oe_r   <= oe_nxt;
  end

  assign out_valid    = ov_r;
  assign out_filtered = of_r;
  assign out_last     = ol_r;
  assign out_err      = oe_r;

endmodule

[src/htf_checker.sv]
// Port-level checks of the horizontal three-tap filter unit, bound to the top.
// Depends on horizontal_three_tap_filter_unit_macros.svh.
`include "horizontal_three_tap_filter_unit_macros.svh"

module htf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  // A stalled word keeps its payload.
  `HTF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))

  // A zero coefficient sum always comes with a zero pixel value.
  `HTF_ASSERT_IMPLY(a_err_zero, clk, rst_n, out_tvalid && out_tuser, out_tdata == 16'd0)

  // Every offered result word carries fully defined bits.
  `HTF_ASSERT_IMPLY(a_out_known, clk, rst_n, out_tvalid, !$isunknown({out_tdata, out_tlast, out_tuser}))

  // The input ready is defined whenever a pixel word is offered.
  `HTF_ASSERT_IMPLY(a_ready_known, clk, rst_n, in_tvalid, !$isunknown(in_tready))

endmodule

bind horizontal_three_tap_filter_unit htf_checker u_htf_checker (.*);

[dv/tb_horizontal_three_tap_filter_unit.sv]
// Self-checking testbench for the horizontal three-tap filter unit.
// Sends pixel words with random gaps and stalls, predicts every filtered word
// in the bench and checks the result stream. Needs htf_pkg and the unit's RTL.
module tb_horizontal_three_tap_filter_unit;

  localparam int ROW_LIMIT     = 4096;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_PIXELS = 1000;

  typedef struct packed {
    logic signed [htf_pkg::SAMPLE_W-1:0] filtered;
    logic                                row_end;
    logic                                zero_sum;
  } pixel_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [15:0] sample
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [15:0] filtered
  logic        out_tlast;
  logic        out_tuser;       // [0] zero_sum_error
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_wdata = '0;

  htf_pkg::htf_cfg_t                   cfg_model;
  logic signed [htf_pkg::SAMPLE_W-1:0] row_left;
  logic signed [htf_pkg::SAMPLE_W-1:0] row_centre;
  logic [11:0]                         row_col;
  pixel_result_t                       expected_pixels[$];
  int                                  mismatch_count = 0;
  bit                                  stalls_on = 1'b1;
  int                                  ready_hold = 0;

  horizontal_three_tap_filter_unit #(.MAX_WIDTH(ROW_LIMIT)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Weighted sum over the three taps, divided by the kernel sum with rounding
  // half away from zero, then clamped to the signed 16-bit range.
  function automatic pixel_result_t weigh_taps(input logic signed [15:0] l, c, r,
                                               input logic last);
    pixel_result_t res;
    longint k0, k1, k2, ksum, num, num_mag, sum_mag, q;
    k0 = cfg_model.coeff_left;
    k1 = cfg_model.coeff_centre;
    k2 = cfg_model.coeff_right;
    ksum = k0 + k1 + k2;
    num = l * k0 + c * k1 + r * k2;
    res.row_end = last;
    res.zero_sum = (ksum == 0);
    res.filtered = '0;
    if (ksum != 0) begin
      num_mag = (num < 0) ? -num : num;
      sum_mag = (ksum < 0) ? -ksum : ksum;
      q = (2 * num_mag + sum_mag) / (2 * sum_mag);
      if ((num < 0) != (ksum < 0)) q = -q;
      if (q > 32767) q = 32767;
      else if (q < -32768) q = -32768;
      res.filtered = q[15:0];
    end
    return res;
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 16)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_coeff();
    case ($urandom_range(0, 5))
      0: return 8'h80;
      1: return 8'h7F;
      2: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input logic [15:0] pix);
    int gap;
    int unsigned w;
    gap = stalls_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // The word is taken: move the row state on and queue what it completes.
    w = cfg_model.row_width;
    if (w < 1) w = 1;
    else if (w > ROW_LIMIT) w = ROW_LIMIT;
    if (w == 1) begin
      expected_pixels.push_back(weigh_taps('0, pix, '0, 1'b1));
      row_left = '0;
      row_centre = '0;
      row_col = '0;
    end else if (row_col == 0) begin
      row_left = '0;
      row_centre = pix;
      row_col = 12'd1;
    end else if (row_col >= w - 1) begin
      expected_pixels.push_back(weigh_taps(row_left, row_centre, pix, 1'b0));
      expected_pixels.push_back(weigh_taps(row_centre, pix, '0, 1'b1));
      row_left = '0;
      row_centre = '0;
      row_col = '0;
    end else begin
      expected_pixels.push_back(weigh_taps(row_left, row_centre, pix, 1'b0));
      row_left = row_centre;
      row_centre = pix;
      row_col = row_col + 12'd1;
    end
  endtask

  task automatic write_reg(input htf_pkg::htf_reg_t idx, input logic [12:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      htf_pkg::REG_ROW_WIDTH:    cfg_model.row_width = val;
      htf_pkg::REG_COEFF_LEFT:   cfg_model.coeff_left = val[7:0];
      htf_pkg::REG_COEFF_CENTRE: cfg_model.coeff_centre = val[7:0];
      htf_pkg::REG_COEFF_RIGHT:  cfg_model.coeff_right = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_kernel(input logic [7:0] k_left, k_centre, k_right);
    write_reg(htf_pkg::REG_COEFF_LEFT, {{5{k_left[7]}}, k_left});
    write_reg(htf_pkg::REG_COEFF_CENTRE, {{5{k_centre[7]}}, k_centre});
    write_reg(htf_pkg::REG_COEFF_RIGHT, {{5{k_right[7]}}, k_right});
  endtask

  // Stops offering words until every expected word is out, then lets the
  // divider settle so that a pixel that completed nothing is fully absorbed.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_kernel();
    // Reset values: a 4096-pixel row and the 1-2-1 kernel.
    send_pixel(16'h7FFF);
    send_pixel(16'h8000);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'h0001);
    send_pixel(16'h7FFF);
    wait_drained();
    // The row is already past the new width, so the next pixel closes it.
    write_reg(htf_pkg::REG_ROW_WIDTH, 13'd3);
    repeat (4) send_pixel(rand_sample());
  endtask

  task automatic test_single_pixel_rows();
    wait_drained();
    write_reg(htf_pkg::REG_ROW_WIDTH, 13'd1);
    set_kernel(8'h7F, 8'h80, 8'h7F);
    send_pixel(16'h7FFF);
    send_pixel(16'h8000);
    send_pixel(16'h0005);
    wait_drained();
    write_reg(htf_pkg::REG_ROW_WIDTH, 13'd0);
    send_pixel(16'h8001);
    send_pixel(16'h0040);
  endtask

  task automatic test_zero_sum();
    wait_drained();
    write_reg(htf_pkg::REG_ROW_WIDTH, 13'd3);
    set_kernel(8'h80, 8'h7F, 8'h01);
    send_pixel(16'h0005);
    send_pixel(16'hFFF9);
    send_pixel(16'h7FFF);
  endtask

  task automatic test_rounding_and_saturation();
    wait_drained();
    set_kernel(8'h7F, 8'h80, 8'h7F);
    send_pixel(16'h7FFF);
    send_pixel(16'h8000);
    send_pixel(16'h7FFF);
    wait_drained();
    // A kernel sum of two puts both results on exact halves.
    write_reg(htf_pkg::REG_ROW_WIDTH, 13'd2);
    set_kernel(8'h01, 8'h00, 8'h01);
    send_pixel(16'h0001);
    send_pixel(16'hFFFF);
    wait_drained();
    set_kernel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(16'h7FFF);
    send_pixel(16'h7FFF);
  endtask

  task automatic test_fill_and_stall();
    wait_drained();
    write_reg(htf_pkg::REG_ROW_WIDTH, 13'd8);
    set_kernel(rand_coeff(), rand_coeff(), rand_coeff());
    stalls_on = 1'b0;
    ready_hold = HOLD_CYCLES;
    repeat (40) send_pixel(rand_sample());
    stalls_on = 1'b1;
  endtask

  task automatic test_widest_row();
    wait_drained();
    // Above the limit the width acts as the limit, so this short run stays open.
    write_reg(htf_pkg::REG_ROW_WIDTH, 13'h1FFF);
    set_kernel(rand_coeff(), rand_coeff(), rand_coeff());
    repeat (24) send_pixel(rand_sample());
  endtask

  task automatic test_random_rows();
    int sent, n, w, k_sum;
    logic [12:0] width_code;
    logic [7:0] k0, k1, k2;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      wait_drained();
      stalls_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: width_code = 13'd0;
        1: width_code = 13'd1;
        2: width_code = 13'($urandom_range(13, 40));
        default: width_code = 13'($urandom_range(2, 12));
      endcase
      write_reg(htf_pkg::REG_ROW_WIDTH, width_code);
      k0 = rand_coeff();
      k1 = rand_coeff();
      k2 = rand_coeff();
      if ($urandom_range(0, 5) == 0) begin
        k_sum = int'($signed(k0)) + int'($signed(k1));
        if (k_sum >= -127 && k_sum <= 128) k2 = 8'(-k_sum);
      end
      set_kernel(k0, k1, k2);
      w = (width_code == 0) ? 1 : int'(width_code);
      // Mostly whole rows; sometimes a partial row that the next setting cuts.
      n = w * $urandom_range(1, 4);
      if ($urandom_range(0, 3) == 0) n += $urandom_range(1, w);
      repeat (n) send_pixel(rand_sample());
      sent += n;
    end
    stalls_on = 1'b1;
  endtask

  initial begin : result_ready
    int wait_n;
    forever begin
      wait_n = stalls_on ? $urandom_range(0, 5) : 0;
      if (ready_hold > 0) begin
        wait_n = ready_hold;
        ready_hold = 0;
      end
      if (wait_n > 0) begin
        out_tready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    pixel_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pixels.size() == 0) begin
        $error("result word with nothing expected: filtered %0d", $signed(out_tdata));
        mismatch_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_tdata !== want.filtered) begin
          $error("filtered: expected %0d, got %0d", want.filtered, $signed(out_tdata));
          mismatch_count++;
        end
        if (out_tlast !== want.row_end) begin
          $error("row_end: expected %0b, got %0b", want.row_end, out_tlast);
          mismatch_count++;
        end
        if (out_tuser !== want.zero_sum) begin
          $error("zero_sum_error: expected %0b, got %0b", want.zero_sum, out_tuser);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    cfg_model = '{htf_pkg::RST_ROW_WIDTH, htf_pkg::RST_COEFF_L, htf_pkg::RST_COEFF_C,
                  htf_pkg::RST_COEFF_R};
    row_left = '0;
    row_centre = '0;
    row_col = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_kernel();
    test_single_pixel_rows();
    test_zero_sum();
    test_rounding_and_saturation();
    test_fill_and_stall();
    test_widest_row();
    test_random_rows();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
